>>> rtl/i2c_register_master_core_defines.svh
// Assertion macros for the I2C register master
`ifndef I2C_REGISTER_MASTER_CORE_DEFINES_SVH
`define I2C_REGISTER_MASTER_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define I2CM_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define I2CM_ASSERT_IMPL(label, clk, rst, ante, cons)
`define I2CM_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif
`endif

>>> rtl/i2cm_pkg.sv
package i2cm_pkg;

   localparam logic [2:0] OP_TICK  = 3'd0;
   localparam logic [2:0] OP_WRITE = 3'd1;
   localparam logic [2:0] OP_DATA  = 3'd2;
   localparam logic [2:0] OP_READ  = 3'd3;
   localparam logic [2:0] OP_BIT   = 3'd4;
   localparam logic [2:0] OP_FIELD = 3'd5;

   localparam logic [2:0] ST_OK       = 3'd0;
   localparam logic [2:0] ST_TIMEOUT  = 3'd1;
   localparam logic [2:0] ST_BUS_BUSY = 3'd2;
   localparam logic [2:0] ST_START    = 3'd3;
   localparam logic [2:0] ST_BAD_REQ  = 3'd4;

   localparam logic CSR_ACK_TIMEOUT = 1'b0;
   localparam logic CSR_PHASE_TICKS = 1'b1;

   localparam logic [7:0] ACK_TIMEOUT_RESET = 8'd50;
   localparam logic [7:0] PHASE_TICKS_RESET = 8'd1;

   typedef enum logic [20:0] {
      PH_IDLE   = 21'h000001,
      PH_ST_A   = 21'h000002,
      PH_ST_B   = 21'h000004,
      PH_ST_C   = 21'h000008,
      PH_ST_D   = 21'h000010,
      PH_W_SET  = 21'h000020,
      PH_W_HIGH = 21'h000040,
      PH_A_REL  = 21'h000080,
      PH_A_HIGH = 21'h000100,
      PH_A_POLL = 21'h000200,
      PH_R_HIGH = 21'h000400,
      PH_R_FALL = 21'h000800,
      PH_M_SET  = 21'h001000,
      PH_M_HIGH = 21'h002000,
      PH_M_LOW  = 21'h004000,
      PH_P_0    = 21'h008000,
      PH_P_1    = 21'h010000,
      PH_P_2    = 21'h020000,
      PH_P_3    = 21'h040000,
      PH_D_WAIT = 21'h080000,
      PH_R_REL  = 21'h100000
   } phase_type;

   typedef enum logic [2:0] {
      EL_START, EL_ADDRW, EL_REG, EL_RESTART, EL_ADDRR, EL_READ, EL_DATA, EL_STOP
   } element_type;

   typedef enum logic [1:0] {
      KIND_WRITE, KIND_READ, KIND_BIT, KIND_FIELD
   } kind_type;

   typedef struct packed {
      logic [2:0] op;
      logic [7:0] dev_addr;
      logic [7:0] reg_addr;
      logic [7:0] data;
      logic [2:0] bit_start;
      logic [3:0] field_len;
      logic [7:0] count;
      logic       sda_in;
   } req_type;

   typedef struct packed {
      logic       scl;
      logic       sda_out;
      logic       sda_drive;
      logic       busy_res;
      logic       need_data;
      logic [7:0] read_data;
      logic       read_valid;
      logic       last;
      logic       done_res;
      logic [2:0] status;
   } rsp_type;

   typedef struct packed {
      logic [7:0] ack_timeout;
      logic [7:0] phase_ticks;
   } csr_type;

   // new register byte for the bit and field commands
   function automatic logic [7:0] modify_byte(input kind_type k, input logic [7:0] got,
                                              input logic [7:0] dat, input logic [2:0] bs,
                                              input logic [3:0] len);
      logic [7:0] m;
      logic [7:0] ones;
      logic [2:0] low;
      m    = 8'd1 << bs;
      ones = 8'((9'd1 << len) - 9'd1);
      low  = 3'(4'(bs) + 4'd1 - len);
      if (k == KIND_BIT) begin
         modify_byte = (dat != 8'd0) ? (got | m) : (got & ~m);
      end else begin
         modify_byte = (got & ~(ones << low)) | ((dat & ones) << low);
      end
   endfunction

endpackage

>>> rtl/i2c_register_master_core.sv
// I2C register master driven by tick transactions. Every request transaction yields one
// response transaction; a transaction is taken each clock cycle unless req_stall is high,
// and its response is in the output register in the next cycle, so the sustained rate is
// one per cycle while the receiver does not stall. The bus moves only on ticks: each SCL
// half-phase lasts phase_ticks ticks, each step set by the sequencer's combinational logic.
`include "i2c_register_master_core_defines.svh"
module i2c_register_master_core import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [2:0] req_op,
   input  logic [7:0] req_dev_addr,
   input  logic [7:0] req_reg_addr,
   input  logic [7:0] req_data,
   input  logic [2:0] req_bit_start,
   input  logic [3:0] req_field_len,
   input  logic [7:0] req_count,
   input  logic       req_sda_in,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_scl,
   output logic       rsp_sda_out,
   output logic       rsp_sda_drive,
   output logic       rsp_busy_res,
   output logic       rsp_need_data,
   output logic [7:0] rsp_read_data,
   output logic       rsp_read_valid,
   output logic       rsp_last,
   output logic       rsp_done_res,
   output logic [2:0] rsp_status,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata
);

   csr_type csr;
   req_type req;
   rsp_type rsp_next;
   rsp_type rsp_ff, rsp_in;
   logic    rsp_valid_ff, rsp_valid_in;
   logic    step;
   logic    idle;

   assign req = '{op: req_op, dev_addr: req_dev_addr, reg_addr: req_reg_addr,
                  data: req_data, bit_start: req_bit_start, field_len: req_field_len,
                  count: req_count, sda_in: req_sda_in};

   // full output register only holds off input while it is itself stalled
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign step      = req_valid && !req_stall;

   i2cm_csr u_csr (
      .clock, .reset, .csr_write, .csr_index, .csr_wdata, .csr
   );

   i2cm_seq u_seq (
      .clock, .reset, .step, .req, .csr, .rsp(rsp_next), .idle
   );

   always_comb begin
      rsp_in       = rsp_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      if (step) begin
         rsp_in       = rsp_next;
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_scl        = rsp_ff.scl;
   assign rsp_sda_out    = rsp_ff.sda_out;
   assign rsp_sda_drive  = rsp_ff.sda_drive;
   assign rsp_busy_res   = rsp_ff.busy_res;
   assign rsp_need_data  = rsp_ff.need_data;
   assign rsp_read_data  = rsp_ff.read_data;
   assign rsp_read_valid = rsp_ff.read_valid;
   assign rsp_last       = rsp_ff.last;
   assign rsp_done_res   = rsp_ff.done_res;
   assign rsp_status     = rsp_ff.status;

   `I2CM_ASSERT_NEXT(a_stall_holds, clock, reset, rsp_valid && rsp_stall, rsp_valid)
   `I2CM_ASSERT_IMPL(a_status_only_done, clock, reset,
                     rsp_valid && !rsp_done_res, rsp_status == ST_OK)
   `I2CM_ASSERT_IMPL(a_last_only_read, clock, reset,
                     rsp_valid && rsp_last, rsp_read_valid)
   `I2CM_ASSERT_IMPL(a_done_not_busy, clock, reset,
                     rsp_valid && rsp_done_res, !rsp_busy_res && idle)

endmodule

>>> rtl/i2cm_csr.sv
module i2cm_csr import i2cm_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write,
   input  logic       csr_index,
   input  logic [7:0] csr_wdata,
   output csr_type    csr
);

   csr_type csr_ff, csr_in;

   always_comb begin
      csr_in = csr_ff;
      if (csr_write) begin
         unique case (csr_index)
            CSR_ACK_TIMEOUT: csr_in.ack_timeout = csr_wdata;
            CSR_PHASE_TICKS: csr_in.phase_ticks = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff <= '{ack_timeout: ACK_TIMEOUT_RESET, phase_ticks: PHASE_TICKS_RESET};
      end else begin
         csr_ff <= csr_in;
      end
   end

   assign csr = csr_ff;

endmodule

>>> rtl/i2cm_seq.sv
module i2cm_seq import i2cm_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    step,
   input  req_type req,
   input  csr_type csr,
   output rsp_type rsp,
   output logic    idle
);

   phase_type   phase_ff, phase_in;
   element_type element_ff, element_in;
   kind_type    kind_ff, kind_in;
   logic [3:0]  bit_index_ff, bit_index_in;
   logic [7:0]  bytes_left_ff, bytes_left_in;
   logic [7:0]  shift_ff, shift_in;
   logic [7:0]  wait_ff, wait_in;
   logic [7:0]  polls_ff, polls_in;
   logic [7:0]  dev_ff, dev_in, reg_ff, reg_in, data_ff, data_in;
   logic [2:0]  bs_ff, bs_in;
   logic [3:0]  fl_ff, fl_in;
   logic        pend_v_ff, pend_v_in;
   logic [7:0]  pend_ff, pend_in;
   logic        scl_ff, scl_in, sda_ff, sda_in_n, drv_ff, drv_in;
   logic        second_ff, second_in;
   logic [2:0]  run_st_ff, run_st_in;
   logic [7:0]  got_ff, got_in;
   logic        busy;
   logic        hold;
   logic [7:0]  pt;
   logic [7:0]  rd_shift;
   logic [3:0]  rd_idx;
   logic [2:0]  bs_req;

   assign busy = (phase_ff != PH_IDLE);
   assign idle = !busy;
   assign pt   = (csr.phase_ticks == 8'd0) ? 8'd1 : csr.phase_ticks;
   assign rd_shift = {shift_ff[6:0], req.sda_in};
   assign rd_idx   = bit_index_ff + 4'd1;
   assign bs_req   = req.bit_start;

   always_comb begin
      phase_in = phase_ff; element_in = element_ff; kind_in = kind_ff;
      bit_index_in = bit_index_ff; bytes_left_in = bytes_left_ff; shift_in = shift_ff;
      wait_in = wait_ff; polls_in = polls_ff;
      dev_in = dev_ff; reg_in = reg_ff; data_in = data_ff; bs_in = bs_ff; fl_in = fl_ff;
      pend_v_in = pend_v_ff; pend_in = pend_ff;
      scl_in = scl_ff; sda_in_n = sda_ff; drv_in = drv_ff;
      second_in = second_ff; run_st_in = run_st_ff; got_in = got_ff;
      hold = 1'b1;
      rsp = '0;

      if (step) begin
         if (req.op == OP_TICK) begin
            if (busy) begin
               if (wait_ff != 8'd0) begin
                  wait_in = wait_ff - 8'd1;
               end else begin
                  unique case (phase_ff)
                     PH_ST_A: begin
                        drv_in = 1'b1; sda_in_n = 1'b1; phase_in = PH_ST_B;
                     end
                     PH_ST_B: begin
                        if (!req.sda_in) begin
                           rsp.done_res = 1'b1; rsp.status = ST_BUS_BUSY;
                           phase_in = PH_IDLE; pend_v_in = 1'b0; hold = 1'b0;
                        end else begin
                           scl_in = 1'b1; phase_in = PH_ST_C;
                        end
                     end
                     PH_ST_C: begin
                        sda_in_n = 1'b0; phase_in = PH_ST_D;
                     end
                     PH_ST_D: begin
                        bit_index_in = 4'd0;
                        if (req.sda_in) begin
                           run_st_in = ST_START; element_in = EL_STOP; phase_in = PH_P_0;
                        end else begin
                           scl_in = 1'b0; phase_in = PH_W_SET;
                           if (element_ff == EL_START) begin
                              element_in = EL_ADDRW; shift_in = {dev_ff[7:1], 1'b0};
                           end else begin
                              element_in = EL_ADDRR; shift_in = {dev_ff[7:1], 1'b1};
                           end
                        end
                     end
                     PH_W_SET: begin
                        scl_in = 1'b0; drv_in = 1'b1; sda_in_n = shift_ff[7];
                        shift_in = {shift_ff[6:0], 1'b0}; phase_in = PH_W_HIGH;
                     end
                     PH_W_HIGH: begin
                        scl_in = 1'b1; bit_index_in = rd_idx;
                        phase_in = (rd_idx >= 4'd8) ? PH_A_REL : PH_W_SET;
                     end
                     PH_A_REL: begin
                        scl_in = 1'b0; drv_in = 1'b0; sda_in_n = 1'b1; phase_in = PH_A_HIGH;
                     end
                     PH_A_HIGH: begin
                        scl_in = 1'b1; polls_in = 8'd0; phase_in = PH_A_POLL;
                     end
                     PH_A_POLL: begin
                        if (!req.sda_in) begin
                           scl_in = 1'b0; bit_index_in = 4'd0;
                           priority case (element_ff)
                              EL_ADDRW: begin
                                 element_in = EL_REG; shift_in = reg_ff; phase_in = PH_W_SET;
                              end
                              EL_REG: begin
                                 if (kind_ff == KIND_WRITE || second_ff) begin
                                    element_in = EL_DATA;
                                    if (kind_ff == KIND_WRITE) begin
                                       phase_in = PH_D_WAIT;
                                    end else begin
                                       shift_in = modify_byte(kind_ff, got_ff, data_ff,
                                                              bs_ff, fl_ff);
                                       phase_in = PH_W_SET;
                                    end
                                 end else begin
                                    element_in = EL_RESTART; phase_in = PH_ST_A;
                                 end
                              end
                              EL_ADDRR: begin
                                 element_in = EL_READ; shift_in = 8'd0; phase_in = PH_R_REL;
                              end
                              default: begin
                                 if (kind_ff == KIND_WRITE && bytes_left_ff != 8'd0) begin
                                    element_in = EL_DATA; phase_in = PH_D_WAIT;
                                 end else begin
                                    element_in = EL_STOP; phase_in = PH_P_0;
                                 end
                              end
                           endcase
                        end else if (polls_ff >= csr.ack_timeout) begin
                           run_st_in = ST_TIMEOUT; element_in = EL_STOP;
                           bit_index_in = 4'd0; phase_in = PH_P_0;
                        end else begin
                           polls_in = polls_ff + 8'd1; hold = 1'b0;
                        end
                     end
                     PH_D_WAIT: begin
                        if (!pend_v_ff) begin
                           hold = 1'b0;
                        end else begin
                           pend_v_in = 1'b0;
                           if (bytes_left_ff != 8'd0) bytes_left_in = bytes_left_ff - 8'd1;
                           bit_index_in = 4'd0;
                           scl_in = 1'b0; drv_in = 1'b1; sda_in_n = pend_ff[7];
                           shift_in = {pend_ff[6:0], 1'b0}; phase_in = PH_W_HIGH;
                        end
                     end
                     PH_R_REL: begin
                        scl_in = 1'b0; drv_in = 1'b0; sda_in_n = 1'b1; phase_in = PH_R_HIGH;
                     end
                     PH_R_HIGH: begin
                        scl_in = 1'b1; phase_in = PH_R_FALL;
                     end
                     PH_R_FALL: begin
                        shift_in = rd_shift; bit_index_in = rd_idx; scl_in = 1'b0;
                        if (rd_idx >= 4'd8) begin
                           got_in = rd_shift;
                           if (kind_ff == KIND_READ) begin
                              rsp.read_valid = 1'b1; rsp.read_data = rd_shift;
                              rsp.last = (bytes_left_ff <= 8'd1);
                           end
                           phase_in = PH_M_SET;
                        end else begin
                           phase_in = PH_R_HIGH;
                        end
                     end
                     PH_M_SET: begin
                        drv_in = 1'b1; sda_in_n = !(bytes_left_ff > 8'd1); phase_in = PH_M_HIGH;
                     end
                     PH_M_HIGH: begin
                        scl_in = 1'b1; phase_in = PH_M_LOW;
                     end
                     PH_M_LOW: begin
                        scl_in = 1'b0;
                        if (bytes_left_ff > 8'd1) begin
                           bytes_left_in = bytes_left_ff - 8'd1;
                           bit_index_in = 4'd0; shift_in = 8'd0;
                           drv_in = 1'b0; sda_in_n = 1'b1; phase_in = PH_R_HIGH;
                        end else begin
                           bytes_left_in = 8'd0; bit_index_in = 4'd0;
                           element_in = EL_STOP; phase_in = PH_P_0;
                        end
                     end
                     PH_P_0: begin
                        scl_in = 1'b0; drv_in = 1'b1; sda_in_n = 1'b0; phase_in = PH_P_1;
                     end
                     PH_P_1: begin
                        scl_in = 1'b1; phase_in = PH_P_2;
                     end
                     PH_P_2: begin
                        sda_in_n = 1'b1; phase_in = PH_P_3;
                     end
                     PH_P_3: begin
                        if (run_st_ff != ST_OK || kind_ff == KIND_WRITE ||
                            kind_ff == KIND_READ || second_ff) begin
                           rsp.done_res = 1'b1; rsp.status = run_st_ff;
                           phase_in = PH_IDLE; pend_v_in = 1'b0; hold = 1'b0;
                        end else begin
                           second_in = 1'b1; element_in = EL_START;
                           bit_index_in = 4'd0; phase_in = PH_ST_A;
                        end
                     end
                     default: begin
                        phase_in = PH_IDLE; hold = 1'b0;
                     end
                  endcase
                  wait_in = hold ? pt - 8'd1 : 8'd0;
               end
            end
         end else if (req.op == OP_DATA) begin
            if (busy && kind_ff == KIND_WRITE && bytes_left_ff != 8'd0 && !pend_v_ff) begin
               pend_v_in = 1'b1; pend_in = req.data;
            end
         end else if (!busy && req.op <= OP_FIELD) begin
            if (((req.op == OP_WRITE || req.op == OP_READ) && req.count == 8'd0) ||
                (req.op == OP_FIELD && (req.field_len == 4'd0 || req.field_len > 4'd8 ||
                 req.field_len > 4'(bs_req) + 4'd1))) begin
               rsp.done_res = 1'b1; rsp.status = ST_BAD_REQ;
               pend_v_in = 1'b0; wait_in = 8'd0;
            end else begin
               dev_in = req.dev_addr; reg_in = req.reg_addr; data_in = req.data;
               bs_in = req.bit_start; fl_in = req.field_len;
               unique case (req.op)
                  OP_WRITE: kind_in = KIND_WRITE;
                  OP_READ:  kind_in = KIND_READ;
                  OP_BIT:   kind_in = KIND_BIT;
                  default:  kind_in = KIND_FIELD;
               endcase
               second_in = 1'b0; run_st_in = ST_OK; pend_v_in = 1'b0;
               wait_in = 8'd0; polls_in = 8'd0;
               bytes_left_in = (req.op == OP_WRITE || req.op == OP_READ) ? req.count : 8'd1;
               element_in = EL_START; bit_index_in = 4'd0; phase_in = PH_ST_A;
            end
         end
      end

      rsp.scl = scl_in; rsp.sda_out = sda_in_n; rsp.sda_drive = drv_in;
      rsp.busy_res = (phase_in != PH_IDLE);
      rsp.need_data = (phase_in != PH_IDLE) && kind_in == KIND_WRITE &&
                      bytes_left_in != 8'd0 && !pend_v_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; element_ff <= EL_START; kind_ff <= KIND_WRITE;
         bit_index_ff <= '0; bytes_left_ff <= '0; shift_ff <= '0;
         wait_ff <= '0; polls_ff <= '0; pend_v_ff <= 1'b0;
         scl_ff <= 1'b1; sda_ff <= 1'b1; drv_ff <= 1'b1;
         second_ff <= 1'b0; run_st_ff <= ST_OK; got_ff <= '0;
         dev_ff <= '0; reg_ff <= '0; data_ff <= '0; bs_ff <= '0; fl_ff <= '0;
      end else begin
         phase_ff <= phase_in; element_ff <= element_in; kind_ff <= kind_in;
         bit_index_ff <= bit_index_in; bytes_left_ff <= bytes_left_in; shift_ff <= shift_in;
         wait_ff <= wait_in; polls_ff <= polls_in; pend_v_ff <= pend_v_in;
         scl_ff <= scl_in; sda_ff <= sda_in_n; drv_ff <= drv_in;
         second_ff <= second_in; run_st_ff <= run_st_in; got_ff <= got_in;
         dev_ff <= dev_in; reg_ff <= reg_in; data_ff <= data_in; bs_ff <= bs_in; fl_ff <= fl_in;
      end
   end

   always_ff @(posedge clock) begin
      pend_ff <= pend_in;
   end

endmodule

>>> verif/tb.sv
`timescale 1ns / 100ps
module tb import i2cm_pkg::*; ();

   localparam int CYCLE_LIMIT = 3000000;
   localparam int TOTAL_ITEMS = 1750;

   // op codes the block has no command for
   localparam logic [2:0] OP_SPARE_A = 3'd6;
   localparam logic [2:0] OP_SPARE_B = 3'd7;

   typedef enum int {FAULT_NONE, FAULT_RANDOM, FAULT_BUS_BUSY, FAULT_START, FAULT_NACK} fault_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic [2:0] req_op = OP_TICK;
   logic [7:0] req_dev_addr = '0;
   logic [7:0] req_reg_addr = '0;
   logic [7:0] req_data = '0;
   logic [2:0] req_bit_start = '0;
   logic [3:0] req_field_len = '0;
   logic [7:0] req_count = '0;
   logic       req_sda_in = 1'b1;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic       rsp_scl, rsp_sda_out, rsp_sda_drive, rsp_busy_res, rsp_need_data;
   logic [7:0] rsp_read_data;
   logic       rsp_read_valid, rsp_last, rsp_done_res;
   logic [2:0] rsp_status;
   logic       csr_write = 1'b0;
   logic       csr_index = CSR_ACK_TIMEOUT;
   logic [7:0] csr_wdata = '0;

   i2c_register_master_core u_top (.*);

   always #1 clock = ~clock;

   rsp_type   expected_rsp[$];
   int        mismatches = 0;
   int        errors = 0;
   int        cycles = 0;
   int        items_sent = 0;
   int        hold_cycles = 0;
   int        burst_left = 0;
   bit        gaps_on = 1'b1;
   fault_type fault = FAULT_NONE;

   // bus model state
   phase_type   m_phase;
   element_type m_elem;
   kind_type    m_kind;
   logic [3:0]  m_bit;
   logic [7:0]  m_left, m_shift, m_wait, m_polls, m_got, m_pend;
   logic        m_pend_v, m_second;
   logic [2:0]  m_run_st;
   logic [7:0]  h_dev, h_reg, h_data;
   logic [2:0]  h_bs;
   logic [3:0]  h_len;
   logic        l_scl, l_sda, l_drv;
   logic        r_valid, r_last, r_done;
   logic [7:0]  r_data;
   logic [2:0]  r_status;
   logic [7:0]  cfg_timeout, cfg_ticks;

   function automatic logic [7:0] new_register_byte();
      logic [7:0] ones, mask;
      logic [2:0] lo;
      if (m_kind == KIND_BIT) begin
         mask = 8'd1 << h_bs;
         return (h_data != 8'd0) ? (m_got | mask) : (m_got & ~mask);
      end
      ones = 8'((9'd1 << h_len) - 9'd1);
      lo   = 3'({1'b0, h_bs} + 4'd1 - h_len);
      mask = ones << lo;
      return (m_got & ~mask) | ((h_data & ones) << lo);
   endfunction

   task automatic begin_element(input element_type e);
      m_elem = e;
      m_bit = '0;
      case (e)
         EL_START, EL_RESTART: m_phase = PH_ST_A;
         EL_ADDRW: begin m_shift = h_dev & 8'hFE; m_phase = PH_W_SET; end
         EL_REG:   begin m_shift = h_reg; m_phase = PH_W_SET; end
         EL_ADDRR: begin m_shift = h_dev | 8'h01; m_phase = PH_W_SET; end
         EL_READ:  begin m_shift = '0; m_phase = PH_R_REL; end
         EL_DATA: begin
            if (m_kind == KIND_WRITE) m_phase = PH_D_WAIT;
            else begin
               m_shift = new_register_byte();
               m_phase = PH_W_SET;
            end
         end
         default: m_phase = PH_P_0;
      endcase
   endtask

   task automatic end_transaction(input logic [2:0] st);
      r_done = 1'b1;
      r_status = st;
      m_phase = PH_IDLE;
      m_pend_v = 1'b0;
      m_wait = '0;
   endtask

   task automatic abort_to_stop(input logic [2:0] st);
      m_run_st = st;
      begin_element(EL_STOP);
   endtask

   task automatic shift_out_bit();
      l_scl = 1'b0;
      l_drv = 1'b1;
      l_sda = m_shift[7];
      m_shift = m_shift << 1;
      m_phase = PH_W_HIGH;
   endtask

   task automatic next_after_ack();
      case (m_elem)
         EL_ADDRW: begin_element(EL_REG);
         EL_REG:   begin_element((m_kind == KIND_WRITE || m_second) ? EL_DATA : EL_RESTART);
         EL_ADDRR: begin_element(EL_READ);
         default:  begin_element((m_kind == KIND_WRITE && m_left > 0) ? EL_DATA : EL_STOP);
      endcase
   endtask

   // one half-phase step; held is set when the new line levels last phase_ticks ticks
   task automatic bus_step(input logic sda, output bit held);
      held = 1'b1;
      case (m_phase)
         PH_ST_A: begin l_drv = 1'b1; l_sda = 1'b1; m_phase = PH_ST_B; end
         PH_ST_B: begin
            if (!sda) begin end_transaction(ST_BUS_BUSY); held = 1'b0; end
            else begin l_scl = 1'b1; m_phase = PH_ST_C; end
         end
         PH_ST_C: begin l_sda = 1'b0; m_phase = PH_ST_D; end
         PH_ST_D: begin
            if (sda) abort_to_stop(ST_START);
            else begin
               l_scl = 1'b0;
               begin_element(m_elem == EL_START ? EL_ADDRW : EL_ADDRR);
            end
         end
         PH_W_SET: shift_out_bit();
         PH_W_HIGH: begin
            l_scl = 1'b1;
            m_bit = m_bit + 4'd1;
            m_phase = (m_bit >= 4'd8) ? PH_A_REL : PH_W_SET;
         end
         PH_A_REL:  begin l_scl = 1'b0; l_drv = 1'b0; l_sda = 1'b1; m_phase = PH_A_HIGH; end
         PH_A_HIGH: begin l_scl = 1'b1; m_polls = '0; m_phase = PH_A_POLL; end
         PH_A_POLL: begin
            if (!sda) begin l_scl = 1'b0; next_after_ack(); end
            else if (m_polls >= cfg_timeout) abort_to_stop(ST_TIMEOUT);
            else begin m_polls = m_polls + 8'd1; held = 1'b0; end
         end
         PH_D_WAIT: begin
            if (!m_pend_v) held = 1'b0;
            else begin
               m_shift = m_pend;
               m_pend_v = 1'b0;
               if (m_left > 0) m_left = m_left - 8'd1;
               m_bit = '0;
               shift_out_bit();
            end
         end
         PH_R_REL:  begin l_scl = 1'b0; l_drv = 1'b0; l_sda = 1'b1; m_phase = PH_R_HIGH; end
         PH_R_HIGH: begin l_scl = 1'b1; m_phase = PH_R_FALL; end
         PH_R_FALL: begin
            m_shift = {m_shift[6:0], sda};
            m_bit = m_bit + 4'd1;
            l_scl = 1'b0;
            if (m_bit >= 4'd8) begin
               m_got = m_shift;
               if (m_kind == KIND_READ) begin
                  r_valid = 1'b1;
                  r_data = m_shift;
                  r_last = (m_left <= 8'd1);
               end
               m_phase = PH_M_SET;
            end else m_phase = PH_R_HIGH;
         end
         PH_M_SET:  begin l_drv = 1'b1; l_sda = (m_left > 8'd1) ? 1'b0 : 1'b1; m_phase = PH_M_HIGH; end
         PH_M_HIGH: begin l_scl = 1'b1; m_phase = PH_M_LOW; end
         PH_M_LOW: begin
            l_scl = 1'b0;
            if (m_left > 0) m_left = m_left - 8'd1;
            if (m_left > 0) begin
               m_bit = '0;
               m_shift = '0;
               l_drv = 1'b0;
               l_sda = 1'b1;
               m_phase = PH_R_HIGH;
            end else begin_element(EL_STOP);
         end
         PH_P_0: begin l_scl = 1'b0; l_drv = 1'b1; l_sda = 1'b0; m_phase = PH_P_1; end
         PH_P_1: begin l_scl = 1'b1; m_phase = PH_P_2; end
         PH_P_2: begin l_sda = 1'b1; m_phase = PH_P_3; end
         PH_P_3: begin
            if (m_run_st != ST_OK || m_kind == KIND_WRITE || m_kind == KIND_READ || m_second) begin
               end_transaction(m_run_st);
               held = 1'b0;
            end else begin
               m_second = 1'b1;
               begin_element(EL_START);
            end
         end
         default: begin m_phase = PH_IDLE; held = 1'b0; end
      endcase
   endtask

   task automatic start_transaction(input kind_type k, input req_type it);
      h_dev = it.dev_addr;
      h_reg = it.reg_addr;
      h_data = it.data;
      h_bs = it.bit_start;
      h_len = it.field_len;
      m_kind = k;
      m_second = 1'b0;
      m_run_st = ST_OK;
      m_pend_v = 1'b0;
      m_wait = '0;
      m_polls = '0;
      m_left = (k == KIND_WRITE || k == KIND_READ) ? it.count : 8'd1;
      begin_element(EL_START);
   endtask

   function automatic bit data_wanted();
      return m_phase != PH_IDLE && m_kind == KIND_WRITE && m_left > 0 && !m_pend_v;
   endfunction

   task automatic predict_bus(input req_type it, output rsp_type r);
      bit busy, held;
      busy = (m_phase != PH_IDLE);
      r_valid = 1'b0; r_data = '0; r_last = 1'b0; r_done = 1'b0; r_status = ST_OK;
      if (it.op == OP_TICK) begin
         if (busy) begin
            if (m_wait > 0) m_wait = m_wait - 8'd1;
            else begin
               bus_step(it.sda_in, held);
               if (held) m_wait = (cfg_ticks == 8'd0) ? 8'd0 : cfg_ticks - 8'd1;
            end
         end
      end else if (it.op == OP_DATA) begin
         if (data_wanted()) begin
            m_pend_v = 1'b1;
            m_pend = it.data;
         end
      end else if (!busy && it.op <= OP_FIELD) begin
         if (it.op == OP_WRITE || it.op == OP_READ) begin
            if (it.count == 8'd0) end_transaction(ST_BAD_REQ);
            else start_transaction(it.op == OP_WRITE ? KIND_WRITE : KIND_READ, it);
         end else if (it.op == OP_BIT) start_transaction(KIND_BIT, it);
         else if (it.field_len == 4'd0 || it.field_len > 4'd8
                  || it.field_len > {1'b0, it.bit_start} + 4'd1)
            end_transaction(ST_BAD_REQ);
         else start_transaction(KIND_FIELD, it);
      end
      r.scl = l_scl;
      r.sda_out = l_sda;
      r.sda_drive = l_drv;
      r.busy_res = (m_phase != PH_IDLE);
      r.need_data = data_wanted();
      r.read_data = r_data;
      r.read_valid = r_valid;
      r.last = r_last;
      r.done_res = r_done;
      r.status = r_status;
   endtask

   // ---------------------------------------------------------------- drivers

   task automatic send_item(input req_type it);
      bit stalled;
      rsp_type r;
      if (gaps_on && burst_left == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 6)) @(posedge clock);
         burst_left = $urandom_range(1, 24);
      end
      if (burst_left > 0) burst_left--;
      req_valid <= 1'b1;
      req_op <= it.op;
      req_dev_addr <= it.dev_addr;
      req_reg_addr <= it.reg_addr;
      req_data <= it.data;
      req_bit_start <= it.bit_start;
      req_field_len <= it.field_len;
      req_count <= it.count;
      req_sda_in <= it.sda_in;
      do begin
         @(negedge clock);
         stalled = req_stall;
         @(posedge clock);
      end while (stalled);
      predict_bus(it, r);
      expected_rsp.push_back(r);
      items_sent++;
   endtask

   function automatic req_type random_item(input logic [2:0] op);
      req_type it;
      logic [63:0] bits;
      bits = {$urandom, $urandom};
      it = bits[$bits(req_type)-1:0];
      it.op = op;
      return it;
   endfunction

   // a device that answers according to the current fault setting
   function automatic logic pick_sda();
      case (m_phase)
         PH_ST_B:   return (fault == FAULT_BUS_BUSY) ? 1'b0 :
                           (fault == FAULT_RANDOM) ? ($urandom_range(0, 99) < 97) : 1'b1;
         PH_ST_D:   return (fault == FAULT_START) ? 1'b1 :
                           (fault == FAULT_RANDOM) ? ($urandom_range(0, 99) < 3) : 1'b0;
         PH_A_POLL: return (fault == FAULT_NACK) ? 1'b1 :
                           (fault == FAULT_RANDOM) ? ($urandom_range(0, 99) < 15) : 1'b0;
         default:   return 1'($urandom_range(0, 1));
      endcase
   endfunction

   task automatic send_tick();
      req_type it;
      it = random_item(OP_TICK);
      it.sda_in = pick_sda();
      send_item(it);
   endtask

   // issues one command and plays the device until the transaction is over
   task automatic run_command(input req_type cmd);
      req_type it;
      int dice;
      send_item(cmd);
      while (m_phase != PH_IDLE) begin
         dice = $urandom_range(0, 99);
         if (dice < 3) begin
            // noise the block must ignore while busy
            it = random_item(3'($urandom_range(1, 7)));
            if (it.op == OP_DATA && data_wanted()) it.op = OP_SPARE_A;
            send_item(it);
         end else if (data_wanted() && dice < 80) send_item(random_item(OP_DATA));
         else send_tick();
      end
   endtask

   function automatic req_type make_cmd(input logic [2:0] op, input logic [7:0] cnt,
                                        input logic [2:0] bs, input logic [3:0] len,
                                        input logic [7:0] dat);
      req_type it;
      it = random_item(op);
      it.count = cnt;
      it.bit_start = bs;
      it.field_len = len;
      it.data = dat;
      return it;
   endfunction

   task automatic wait_all_checked();
      req_valid <= 1'b0;
      while (expected_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_csr(input logic idx, input logic [7:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      if (idx == CSR_ACK_TIMEOUT) cfg_timeout = val;
      else cfg_ticks = val;
   endtask

   task automatic set_config(input logic [7:0] timeout, input logic [7:0] ticks);
      wait_all_checked();
      write_csr(CSR_ACK_TIMEOUT, timeout);
      write_csr(CSR_PHASE_TICKS, ticks);
      csr_write <= 1'b0;
   endtask

   // ------------------------------------------------------------------ tests

   task automatic test_commands();
      fault = FAULT_NONE;
      run_command(make_cmd(OP_WRITE, 8'd1, 3'd0, 4'd1, 8'hFF));
      run_command(make_cmd(OP_BIT, 8'd0, 3'd7, 4'd0, 8'h01));
      run_command(make_cmd(OP_FIELD, 8'd0, 3'd5, 4'd3, 8'h06));
   endtask

   task automatic test_bad_requests();
      run_command(make_cmd(OP_WRITE, 8'd0, 3'd0, 4'd1, 8'h00));
      run_command(make_cmd(OP_READ, 8'd0, 3'd0, 4'd1, 8'h00));
      run_command(make_cmd(OP_FIELD, 8'd0, 3'd7, 4'd0, 8'h00));
      run_command(make_cmd(OP_FIELD, 8'd0, 3'd7, 4'd9, 8'h00));
      run_command(make_cmd(OP_FIELD, 8'd0, 3'd2, 4'd4, 8'h00));
      run_command(make_cmd(OP_FIELD, 8'd0, 3'd7, 4'd15, 8'h00));
      send_item(random_item(OP_SPARE_A));
      send_item(random_item(OP_SPARE_B));
      send_item(random_item(OP_DATA));
      send_tick();
   endtask

   task automatic test_bus_faults();
      fault = FAULT_BUS_BUSY;
      run_command(make_cmd(OP_READ, 8'd2, 3'd0, 4'd1, 8'h00));
      fault = FAULT_START;
      run_command(make_cmd(OP_WRITE, 8'd2, 3'd0, 4'd1, 8'h00));
      fault = FAULT_NACK;
      run_command(make_cmd(OP_BIT, 8'd0, 3'd3, 4'd1, 8'h01));
      fault = FAULT_NONE;
   endtask

   task automatic test_config_extremes();
      set_config(8'd1, 8'd2);
      fault = FAULT_NACK;
      run_command(make_cmd(OP_WRITE, 8'd1, 3'd0, 4'd1, 8'h00));
      // longest half-phase: the first half-phase is held before the bus check
      set_config(8'd255, 8'd255);
      fault = FAULT_BUS_BUSY;
      run_command(make_cmd(OP_READ, 8'd1, 3'd0, 4'd1, 8'h00));
      // zero settings: phase_ticks behaves as one, ack_timeout aborts on first high
      set_config(8'd0, 8'd0);
      fault = FAULT_RANDOM;
      repeat (2) run_command(make_cmd(OP_WRITE, 8'd2, 3'd0, 4'd1, 8'h00));
      fault = FAULT_NONE;
      run_command(make_cmd(OP_READ, 8'd2, 3'd0, 4'd1, 8'h00));
      set_config(ACK_TIMEOUT_RESET, PHASE_TICKS_RESET);
   endtask

   task automatic test_long_bursts();
      fault = FAULT_NONE;
      run_command(make_cmd(OP_WRITE, 8'd5, 3'd0, 4'd1, 8'h00));
   endtask

   task automatic test_backpressure();
      bit saved;
      saved = gaps_on;
      gaps_on = 1'b0;
      fault = FAULT_NONE;
      hold_cycles = 400;
      send_item(make_cmd(OP_READ, 8'd6, 3'd0, 4'd1, 8'h00));
      repeat (150) send_tick();
      run_command(make_cmd(OP_READ, 8'd1, 3'd0, 4'd1, 8'h00));
      // sender pauses until the block has answered everything
      wait_all_checked();
      gaps_on = saved;
   endtask

   task automatic test_random();
      req_type cmd;
      int target, dice, share;
      share = (TOTAL_ITEMS - items_sent) / 4;
      for (int p = 0; p < 4; p++) begin
         set_config(8'($urandom_range(1, 60)), 8'($urandom_range(1, 3)));
         gaps_on = (p != 1);
         target = items_sent + share;
         while (items_sent < target) begin
            dice = $urandom_range(0, 99);
            fault = (dice < 80) ? FAULT_RANDOM : (dice < 88) ? FAULT_NONE :
                    (dice < 92) ? FAULT_BUS_BUSY : (dice < 96) ? FAULT_START : FAULT_NACK;
            case ($urandom_range(0, 9))
               0, 1, 2: cmd = random_item(OP_WRITE);
               3, 4, 5: cmd = random_item(OP_READ);
               6:       cmd = random_item(OP_BIT);
               7, 8:    cmd = random_item(OP_FIELD);
               default: cmd = random_item(3'($urandom_range(0, 7)));
            endcase
            cmd.count = ($urandom_range(0, 19) != 0) ? 8'($urandom_range(1, 4)) : 8'd0;
            if (cmd.op == OP_FIELD && $urandom_range(0, 3) != 0)
               cmd.field_len = 4'($urandom_range(1, cmd.bit_start + 1));
            if (cmd.op == OP_TICK || cmd.op == OP_DATA) send_item(cmd);
            else run_command(cmd);
         end
      end
   endtask

   // ---------------------------------------------------------------- checker

   always begin : rsp_monitor
      bit      take;
      rsp_type got, exp;
      @(negedge clock);
      take = !reset && rsp_valid && !rsp_stall;
      got = '{rsp_scl, rsp_sda_out, rsp_sda_drive, rsp_busy_res, rsp_need_data,
              rsp_read_data, rsp_read_valid, rsp_last, rsp_done_res, rsp_status};
      @(posedge clock);
      if (take) begin
         if (expected_rsp.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected response transaction %p", got);
         end else begin
            exp = expected_rsp.pop_front();
            if (got.scl !== exp.scl || got.sda_out !== exp.sda_out
                || got.sda_drive !== exp.sda_drive || got.busy_res !== exp.busy_res
                || got.need_data !== exp.need_data || got.read_data !== exp.read_data
                || got.read_valid !== exp.read_valid || got.last !== exp.last
                || got.done_res !== exp.done_res || got.status !== exp.status) begin
               mismatches++;
               errors++;
               if (mismatches <= 10) $display("mismatch: expected %p actual %p", exp, got);
            end
         end
      end
   end

   // receiver stall pattern, with an occasional long hold-off
   logic [15:0] stall_pattern = '0;
   logic [3:0]  stall_pos = '0;
   always @(posedge clock) begin
      if (hold_cycles > 0) begin
         rsp_stall <= 1'b1;
         hold_cycles = hold_cycles - 1;
      end else begin
         stall_pos <= stall_pos + 4'd1;
         if (stall_pos == 4'd15) begin
            case ($urandom_range(0, 3))
               0:       stall_pattern <= '0;
               1:       stall_pattern <= 16'($urandom);
               2:       stall_pattern <= 16'($urandom & $urandom);
               default: stall_pattern <= 16'($urandom | $urandom);
            endcase
         end
         rsp_stall <= stall_pattern[stall_pos];
      end
   end

   initial begin : watchdog
      while (cycles < CYCLE_LIMIT) @(posedge clock) cycles++;
      $display("TEST FAILED");
      $finish;
   end

   initial begin
      m_phase = PH_IDLE; m_elem = EL_START; m_kind = KIND_WRITE;
      m_bit = '0; m_left = '0; m_shift = '0; m_wait = '0; m_polls = '0;
      m_got = '0; m_pend = '0; m_pend_v = 1'b0; m_second = 1'b0; m_run_st = ST_OK;
      h_dev = '0; h_reg = '0; h_data = '0; h_bs = '0; h_len = '0;
      l_scl = 1'b1; l_sda = 1'b1; l_drv = 1'b1;
      cfg_timeout = ACK_TIMEOUT_RESET;
      cfg_ticks = PHASE_TICKS_RESET;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_commands();
      test_bad_requests();
      test_bus_faults();
      test_config_extremes();
      test_long_bursts();
      test_backpressure();
      test_random();

      wait_all_checked();
      repeat (10) @(posedge clock);
      errors += expected_rsp.size();
      if (errors == 0) $display("TEST PASSED");
      else $display("TEST FAILED");
      $finish;
   end

endmodule
